// ===== src/aegp_pkg.sv =====
// Shared types, constants and arithmetic helpers of the audio gesture pose block.
`default_nettype none
package aegp_pkg;

	localparam int ENERGY_W   = 42;
	localparam int LEN_W      = 17;
	localparam int BONES      = 13;
	localparam int MAX_FRAME_DEFAULT = 4096;
	localparam logic [3:0] BONE_LAST = 4'd12;

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_CLOSE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [2:0] REG_SPF   = 3'd0;
	localparam logic [2:0] REG_ASWAY = 3'd1;
	localparam logic [2:0] REG_ANOD  = 3'd2;
	localparam logic [2:0] REG_ARAISE = 3'd3;
	localparam logic [2:0] REG_PBASE = 3'd4;
	localparam logic [2:0] REG_PGAIN = 3'd5;
	localparam logic [2:0] REG_PERIOD = 3'd6;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [15:0] sample;
	} in_word_t;

	typedef struct packed {
		logic [3:0]         bone_index;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
		logic [39:0]        stamp_us;
		logic               last;
	} out_word_t;

	typedef struct packed {
		logic [12:0] frame_samples;
		logic [14:0] alpha_sway;
		logic [14:0] alpha_nod;
		logic [14:0] alpha_raise;
		logic [15:0] phase_step_base;
		logic [15:0] phase_step_gain;
		logic [19:0] frame_period_us;
	} cfg_t;

	typedef struct packed {
		logic                clear;
		logic [ENERGY_W-1:0] energy;
		logic [LEN_W-1:0]    len;
	} job_t;

	typedef struct packed {
		logic push;
		logic full;
	} qctl_t;

	typedef enum logic [2:0] {
		B_IDLE, B_DIV, B_SQRT, B_CALC, B_BONE
	} back_state_t;

	typedef enum logic [2:0] {
		SRC_SWAY, SRC_SW, SRC_NSW, SRC_NOD, SRC_RAISE, SRC_ASW
	} src_t;

	typedef struct packed {
		logic        ident;
		logic [1:0]  axis;
		logic        neg;
		src_t        src;
		logic [14:0] coef;
	} bone_spec_t;

	function automatic bone_spec_t bone_spec(input logic [3:0] b);
		bone_spec_t s;
		s = '{ident: 1'b1, axis: 2'd0, neg: 1'b0, src: SRC_SWAY, coef: 15'd0};
		case (b)
			4'd0:  s = '{1'b0, 2'd0, 1'b0, SRC_SWAY,  15'd13107};
			4'd1:  s = '{1'b0, 2'd2, 1'b0, SRC_SW,    15'd6554};
			4'd2:  s = '{1'b0, 2'd2, 1'b0, SRC_NSW,   15'd3277};
			4'd3:  s = '{1'b0, 2'd0, 1'b0, SRC_NOD,   15'd13107};
			4'd4:  s = '{1'b0, 2'd0, 1'b0, SRC_NOD,   15'd19661};
			4'd5:  s = '{1'b0, 2'd2, 1'b0, SRC_RAISE, 15'd9830};
			4'd6:  s = '{1'b0, 2'd1, 1'b0, SRC_SW,    15'd19661};
			4'd7:  s = '{1'b0, 2'd2, 1'b0, SRC_ASW,   15'd9830};
			4'd9:  s = '{1'b0, 2'd2, 1'b1, SRC_RAISE, 15'd9830};
			4'd10: s = '{1'b0, 2'd1, 1'b0, SRC_NSW,   15'd19661};
			4'd11: s = '{1'b0, 2'd2, 1'b1, SRC_ASW,   15'd9830};
			default: ;
		endcase
		return s;
	endfunction

	function automatic logic [14:0] sine_tab(input logic [4:0] i);
		logic [14:0] v;
		case (i)
			5'd0:  v = 15'd0;
			5'd1:  v = 15'd3212;
			5'd2:  v = 15'd6393;
			5'd3:  v = 15'd9512;
			5'd4:  v = 15'd12539;
			5'd5:  v = 15'd15446;
			5'd6:  v = 15'd18204;
			5'd7:  v = 15'd20787;
			5'd8:  v = 15'd23170;
			5'd9:  v = 15'd25329;
			5'd10: v = 15'd27245;
			5'd11: v = 15'd28898;
			5'd12: v = 15'd30273;
			5'd13: v = 15'd31356;
			5'd14: v = 15'd32137;
			5'd15: v = 15'd32609;
			default: v = 15'd32767;
		endcase
		return v;
	endfunction

	// quarter-wave table with linear interpolation, angle in 1/65536 turns
	function automatic logic signed [15:0] sin16(input logic [15:0] a);
		logic [14:0] wpos;
		logic [4:0]  idx;
		logic [9:0]  frac;
		logic [14:0] d;
		logic [25:0] p;
		logic [14:0] v;
		wpos = {1'b0, a[13:0]};
		if (a[14]) wpos = 15'h4000 - wpos;
		idx  = wpos[14:10];
		frac = wpos[9:0];
		if (idx[4]) begin
			v = 15'd32767;
		end else begin
			d = sine_tab(idx + 5'd1) - sine_tab(idx);
			p = 26'(d) * 26'(frac) + 26'd512;
			v = sine_tab(idx) + 15'(p[25:10]);
		end
		return a[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
	endfunction

	// Q15 product rounding: add half, floor
	function automatic logic signed [20:0] q15_round(input logic signed [35:0] p);
		logic signed [35:0] t;
		t = p + 36'sd16384;
		return t[35:15];
	endfunction

endpackage
`default_nettype wire

// ===== src/aegp_front.sv =====
// Sample accumulator: sums squared samples and hands finished frames to the queue.
`default_nettype none
module aegp_front #(
	parameter int MAX_FRAME_SAMPLES = aegp_pkg::MAX_FRAME_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire aegp_pkg::in_word_t in_data,
	input  wire logic [12:0]       frame_samples,
	input  wire logic              q_full,
	output aegp_pkg::qctl_t        qctl,
	output aegp_pkg::job_t         job
);
	import aegp_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_SAMPLES);
	localparam logic [ENERGY_W-1:0] E_MAX = '1;

	logic [ENERGY_W-1:0] energy_q;
	logic [CNT_W-1:0]    count_q;
	logic [LEN_W-1:0]    flen;
	logic [31:0]         sq;
	logic [ENERGY_W:0]   e_sum;
	logic [ENERGY_W-1:0] e_next;
	logic [LEN_W-1:0]    cnt_next;
	logic                accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		flen = {4'd0, frame_samples};
		if (flen == '0) flen = LEN_W'(1);
		if (flen > MAX_LEN) flen = MAX_LEN;
		sq       = 32'($signed(in_data.sample) * $signed(in_data.sample));
		e_sum    = {1'b0, energy_q} + (ENERGY_W+1)'(sq);
		e_next   = e_sum[ENERGY_W] ? E_MAX : e_sum[ENERGY_W-1:0];
		cnt_next = LEN_W'(count_q) + LEN_W'(1);
	end

	always_comb begin
		qctl.push  = 1'b0;
		qctl.full  = q_full;
		job.clear  = 1'b0;
		job.energy = energy_q;
		job.len    = flen;
		if (accept) begin
			case (in_data.command)
				CMD_SAMPLE: begin
					job.energy = e_next;
					qctl.push  = (cnt_next >= flen);
				end
				CMD_CLOSE: qctl.push = (count_q != '0);
				CMD_CLEAR: begin
					qctl.push = 1'b1;
					job.clear = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
			count_q  <= '0;
		end else if (accept) begin
			case (in_data.command)
				CMD_SAMPLE: begin
					if (cnt_next >= flen) begin
						energy_q <= '0;
						count_q  <= '0;
					end else begin
						energy_q <= e_next;
						count_q  <= cnt_next[CNT_W-1:0];
					end
				end
				CMD_CLOSE, CMD_CLEAR: begin
					energy_q <= '0;
					count_q  <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/aegp_queue.sv =====
// Two-entry job queue between the accumulator and the frame engine.
`default_nettype none
module aegp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire aegp_pkg::qctl_t qctl,
	input  wire aegp_pkg::job_t  wr_job,
	input  wire logic            pop,
	output logic                 full,
	output logic                 nonempty,
	output aegp_pkg::job_t       rd_job
);
	import aegp_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign rd_job   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (qctl.push) mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (qctl.push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(qctl.push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== src/aegp_back.sv =====
// Frame engine: divide, square root, level filters, oscillator and bone rotations.
`default_nettype none
module aegp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire aegp_pkg::cfg_t   cfg,
	input  wire logic             q_nonempty,
	input  wire aegp_pkg::job_t   job,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output aegp_pkg::out_word_t   out_data
);
	import aegp_pkg::*;

	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(ENERGY_W - 1);
	localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ENERGY_W/2 - 1);
	localparam logic [CNT_W-1:0] CALC_LAST = CNT_W'(9);
	localparam logic [ENERGY_W-1:0] SQRT_BIT0 = ENERGY_W'(1) << (ENERGY_W - 2);

	back_state_t state_q, state_d;

	logic [CNT_W-1:0]    cnt_q;
	logic [LEN_W:0]      rem_q;
	logic [ENERGY_W-1:0] quo_q;
	logic [LEN_W-1:0]    len_q;
	logic [ENERGY_W-1:0] v_q, res_q, bit_q;
	logic [14:0]         rms_q;
	logic [15:0]         prev_q, sway_q, nod_q, raise_q, phase_q, nodt_q;
	logic [39:0]         time_q;
	logic signed [15:0]  sin_q, sw_q;
	logic signed [17:0]  opa_q, opb_q;
	logic signed [35:0]  prod;
	logic [3:0]          bone_q;
	logic [2:0]          bstep_q;
	logic [15:0]         h_q;
	logic signed [15:0]  qx_q, qy_q, qz_q, qw_q;
	logic                out_valid_q;
	out_word_t           out_q;

	logic signed [20:0]  mq;
	logic [LEN_W:0]      rtry;
	logic [ENERGY_W-1:0] rb;
	logic [15:0]         onset;
	logic [17:0]         o5;
	logic [15:0]         sway_c, nod_c, raise_c;
	logic signed [15:0]  asw, srcv, s_h, c_h;
	bone_spec_t          spec;
	logic                div_done, sqrt_done, calc_done, frame_done, emit;

	// shared multiplier: operands registered, product used in the following step
	assign prod = opa_q * opb_q;
	assign mq   = q15_round(prod);
	assign rtry = {rem_q[LEN_W-1:0], quo_q[ENERGY_W-1]};
	assign rb   = res_q + bit_q;
	assign spec = bone_spec(bone_q);
	assign s_h  = sin16(h_q);
	assign c_h  = sin16(h_q + 16'h4000);
	assign emit = (state_q == B_BONE) && (bstep_q == 3'd4) && (!out_valid_q || out_ready);

	always_comb begin
		onset   = (16'(rms_q) > prev_q) ? 16'(rms_q) - prev_q : 16'd0;
		o5      = ({2'd0, onset} * 18'd5) >> 1;
		sway_c  = (sway_q > 16'd2860) ? 16'd2860 : sway_q;
		nod_c   = (nod_q > 16'd4575) ? 16'd4575 : nod_q;
		raise_c = (raise_q > 16'd8579) ? 16'd8579 : raise_q;
		asw     = sw_q[15] ? -sw_q : sw_q;
		case (spec.src)
			SRC_SWAY:  srcv = $signed(sway_c);
			SRC_SW:    srcv = sw_q;
			SRC_NSW:   srcv = -sw_q;
			SRC_NOD:   srcv = $signed(nod_c);
			SRC_RAISE: srcv = $signed(raise_c);
			SRC_ASW:   srcv = asw;
			default:   srcv = 16'sd0;
		endcase
	end

	assign div_done   = (cnt_q == DIV_LAST);
	assign sqrt_done  = (cnt_q == SQRT_LAST);
	assign calc_done  = (cnt_q == CALC_LAST);
	assign frame_done = emit && (bone_q == BONE_LAST);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: if (q_nonempty && !job.clear) state_d = B_DIV;
			B_DIV:  if (div_done) state_d = B_SQRT;
			B_SQRT: if (sqrt_done) state_d = B_CALC;
			B_CALC: if (calc_done) state_d = B_BONE;
			B_BONE: if (frame_done) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == B_IDLE) && q_nonempty;
		out_valid = out_valid_q;
		out_data  = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			bone_q      <= '0;
			bstep_q     <= '0;
			out_valid_q <= 1'b0;
			prev_q      <= '0;
			sway_q      <= '0;
			nod_q       <= '0;
			raise_q     <= '0;
			phase_q     <= '0;
			time_q      <= '0;
		end else begin
			state_q <= state_d;
			// a new word replaces the held one; otherwise drop it once taken
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					cnt_q <= '0;
					if (pop && job.clear) begin
						prev_q  <= '0;
						sway_q  <= '0;
						nod_q   <= '0;
						raise_q <= '0;
						phase_q <= '0;
						time_q  <= '0;
					end
				end
				B_DIV, B_SQRT: cnt_q <= (state_d == state_q) ? cnt_q + CNT_W'(1) : '0;
				B_CALC: begin
					cnt_q <= cnt_q + CNT_W'(1);
					case (cnt_q)
						6'd0: begin
							prev_q <= 16'(rms_q);
							nodt_q <= (o5 > 18'd32767) ? 16'd32767 : o5[15:0];
						end
						6'd2: sway_q  <= sway_q + mq[15:0];
						6'd4: raise_q <= raise_q + mq[15:0];
						6'd5: nod_q   <= nod_q + mq[15:0];
						6'd6: phase_q <= phase_q + cfg.phase_step_base + prod[30:15];
						default: ;
					endcase
					if (calc_done) begin
						bone_q  <= '0;
						bstep_q <= '0;
					end
				end
				B_BONE: begin
					case (bstep_q)
						3'd0: bstep_q <= spec.ident ? 3'd4 : 3'd1;
						3'd1, 3'd2, 3'd3: bstep_q <= bstep_q + 3'd1;
						default: begin
							if (emit) begin
								bstep_q <= '0;
								if (frame_done) time_q <= time_q + 40'(cfg.frame_period_us);
								else bone_q <= bone_q + 4'd1;
							end
						end
					endcase
				end
				default: ;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				rem_q <= '0;
				quo_q <= job.energy;
				len_q <= job.len;
			end
			B_DIV: begin
				// restoring divide, one quotient bit per cycle
				if (rtry >= {1'b0, len_q}) begin
					rem_q <= rtry - {1'b0, len_q};
					quo_q <= {quo_q[ENERGY_W-2:0], 1'b1};
				end else begin
					rem_q <= rtry;
					quo_q <= {quo_q[ENERGY_W-2:0], 1'b0};
				end
				if (div_done) begin
					v_q   <= {quo_q[ENERGY_W-2:0], (rtry >= {1'b0, len_q})};
					res_q <= '0;
					bit_q <= SQRT_BIT0;
				end
			end
			B_SQRT: begin
				// one result bit per cycle
				if (v_q >= rb) begin
					v_q   <= v_q - rb;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (sqrt_done) begin
					if (v_q >= rb)
						rms_q <= (((res_q >> 1) + bit_q) > 42'd32767) ? 15'h7FFF
							: 15'((res_q >> 1) + bit_q);
					else
						rms_q <= ((res_q >> 1) > 42'd32767) ? 15'h7FFF : 15'(res_q >> 1);
				end
			end
			B_CALC: begin
				case (cnt_q)
					6'd0: begin
						opa_q <= 18'(rms_q);
						opb_q <= 18'sd13107;
					end
					6'd1: begin
						opa_q <= 18'(cfg.alpha_sway);
						opb_q <= mq[17:0] - $signed({2'b00, sway_q});
					end
					6'd2: begin
						opa_q <= 18'(rms_q);
						opb_q <= 18'sd19661;
					end
					6'd3: begin
						opa_q <= 18'(cfg.alpha_raise);
						opb_q <= mq[17:0] - $signed({2'b00, raise_q});
					end
					6'd4: begin
						opa_q <= 18'(cfg.alpha_nod);
						opb_q <= $signed({2'b00, nodt_q}) - $signed({2'b00, nod_q});
					end
					6'd5: begin
						opa_q <= 18'(cfg.phase_step_gain);
						opb_q <= 18'(rms_q);
					end
					6'd7: sin_q <= sin16(phase_q);
					6'd8: begin
						opa_q <= 18'(sin_q);
						opb_q <= $signed({2'b00, raise_q});
					end
					6'd9: begin
						if (mq > 21'sd5719) sw_q <= 16'sd5719;
						else if (mq < -21'sd5719) sw_q <= -16'sd5719;
						else sw_q <= mq[15:0];
					end
					default: ;
				endcase
			end
			B_BONE: begin
				case (bstep_q)
					3'd0: begin
						opa_q <= 18'(srcv);
						opb_q <= 18'(spec.coef);
						qx_q  <= 16'sd0;
						qy_q  <= 16'sd0;
						qz_q  <= 16'sd0;
						qw_q  <= 16'sd32767;
					end
					3'd1: begin
						opa_q <= mq[17:0];
						opb_q <= 18'sd5215;
					end
					3'd2: h_q <= mq[15:0];
					3'd3: begin
						case (spec.axis)
							2'd0:    qx_q <= spec.neg ? -s_h : s_h;
							2'd1:    qy_q <= spec.neg ? -s_h : s_h;
							default: qz_q <= spec.neg ? -s_h : s_h;
						endcase
						qw_q <= c_h;
					end
					default: begin
						if (emit) begin
							out_q.bone_index <= bone_q;
							out_q.quat_x     <= qx_q;
							out_q.quat_y     <= qy_q;
							out_q.quat_z     <= qz_q;
							out_q.quat_w     <= qw_q;
							out_q.stamp_us   <= time_q;
							out_q.last       <= (bone_q == BONE_LAST);
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	a_bone_range: assert property (@(posedge clk) disable iff (!arst_n)
		bone_q <= BONE_LAST) else $error("bone counter past last bone");
	a_last_bone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.last |-> out_q.bone_index == BONE_LAST)
		else $error("last flag on wrong bone");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_nonempty) else $error("pop from empty queue");
	a_div_to_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |=> state_q == B_DIV || state_q == B_SQRT)
		else $error("divider left early");

endmodule
`default_nettype wire

// ===== src/audio_energy_gesture_pose.sv =====
// Top level of the audio energy gesture pose generator.
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+------------------------------
//  input    | in_valid, in_ready, in_data      | one command word
//  output   | out_valid, out_ready, out_data   | one bone rotation word
//  config   | cfg_we, cfg_index, cfg_data      | one register write, no wait
//
// The accumulator handles each accepted sample, close or clear word; in_ready
// drops only while the two-entry job queue is full. A frame job passes
// through the engine as a pop, 42 divide steps, 21 square root steps, 10
// filter and oscillator steps on the shared multiplier, then the bone steps,
// where an identity bone skips the rotation steps. Reset clears the control
// state and loads the register defaults; the datapath registers are not reset.
// A stalled output word holds the engine at its emit step; the accumulator
// keeps taking words until the queue fills.
`default_nettype none
module audio_energy_gesture_pose #(
	parameter int MAX_FRAME_SAMPLES = aegp_pkg::MAX_FRAME_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire aegp_pkg::in_word_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output aegp_pkg::out_word_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [19:0]         cfg_data
);
	import aegp_pkg::*;

	cfg_t  cfg_q;
	qctl_t qctl;
	job_t  wr_job, rd_job;
	logic  q_full, q_nonempty, pop;

	// register file; write only while no word is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_samples   <= 13'd533;
			cfg_q.alpha_sway      <= 15'd2113;
			cfg_q.alpha_nod       <= 15'd11167;
			cfg_q.alpha_raise     <= 15'd4090;
			cfg_q.phase_step_base <= 16'd3277;
			cfg_q.phase_step_gain <= 16'd1092;
			cfg_q.frame_period_us <= 20'd33333;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPF:    cfg_q.frame_samples   <= cfg_data[12:0];
				REG_ASWAY:  cfg_q.alpha_sway      <= cfg_data[14:0];
				REG_ANOD:   cfg_q.alpha_nod       <= cfg_data[14:0];
				REG_ARAISE: cfg_q.alpha_raise     <= cfg_data[14:0];
				REG_PBASE:  cfg_q.phase_step_base <= cfg_data[15:0];
				REG_PGAIN:  cfg_q.phase_step_gain <= cfg_data[15:0];
				REG_PERIOD: cfg_q.frame_period_us <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: accumulate energy, close frames, forward clears
	aegp_front #(.MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.frame_samples (cfg_q.frame_samples),
		.q_full        (q_full),
		.qctl          (qctl),
		.job           (wr_job)
	);

	// decouple the two sides
	aegp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.qctl     (qctl),
		.wr_job   (wr_job),
		.pop      (pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.rd_job   (rd_job)
	);

	// back: per-frame math and the bone word stream
	aegp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_nonempty (q_nonempty),
		.job        (rd_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire

// ===== sim/audio_energy_gesture_pose_tb.sv =====
// Self-checking testbench of the audio energy gesture pose generator.
`default_nettype none
module audio_energy_gesture_pose_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import aegp_pkg::*;

	// spare command code: the block must drop it without a result
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// cycles without any accepted word before the run is called hung
	localparam int HANG_LIMIT = 20000;
	// engine drain time after the last expected word (one frame job plus margin)
	localparam int DRAIN_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [19:0] cfg_data = '0;

	audio_energy_gesture_pose dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Pose predictor: register copies and frame state
	// ---------------------------------------------------------------
	int unsigned frame_len_reg, alpha_sway_reg, alpha_nod_reg, alpha_raise_reg;
	int unsigned step_base_reg, step_gain_reg, period_reg;

	longint unsigned energy_acc;
	int unsigned     sample_cnt;
	int              last_rms, sway_lvl, nod_lvl, raise_lvl;
	int unsigned     osc_turns;
	longint unsigned stamp_now;

	in_word_t  word_feed[$];      // command words waiting for the driver
	out_word_t pose_expected[$];  // bone words the block owes us

	int  error_count = 0;
	bit  calm = 1'b0;             // no idling in the last part of the run
	int  send_gap = 0;
	int  recv_stall = 0;
	int  hang_count = 0;

	const int quarter_wave[17] = '{0, 3212, 6393, 9512, 12539, 15446, 18204, 20787,
		23170, 25329, 27245, 28898, 30273, 31356, 32137, 32609, 32767};

	function automatic int mul_round(longint a, longint b);
		return int'((a * b + 64'sd16384) >>> 15);
	endfunction

	function automatic int sine_turns(int unsigned ang);
		int unsigned a, quad, w, idx, fr;
		int v;
		a = ang & 32'hFFFF;
		quad = a >> 14;
		w = a & 32'h3FFF;
		if (quad & 1) w = 32'h4000 - w;
		idx = w >> 10;
		fr = w & 1023;
		if (idx >= 16) v = 32767;
		else v = quarter_wave[idx] + (((quarter_wave[idx+1] - quarter_wave[idx]) * fr + 512) >> 10);
		return (quad >= 2) ? -v : v;
	endfunction

	function automatic int unsigned root_floor(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return int'(res);
	endfunction

	function automatic int clip(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic int unsigned eff_frame_len();
		if (frame_len_reg == 0) return 1;
		if (frame_len_reg > MAX_FRAME_DEFAULT) return MAX_FRAME_DEFAULT;
		return frame_len_reg;
	endfunction

	// axis -1 gives the identity rotation
	function automatic void push_bone(int bone, int axis, bit neg, int angle);
		out_word_t o;
		int q[4];
		int half, s;
		q = '{0, 0, 0, 32767};
		if (axis >= 0) begin
			half = mul_round(angle, 5215) & 32'hFFFF;
			s = sine_turns(half);
			q[axis] = neg ? -s : s;
			q[3] = sine_turns(half + 32'h4000);
		end
		o.bone_index = 4'(bone);
		o.quat_x = q[0][15:0];
		o.quat_y = q[1][15:0];
		o.quat_z = q[2][15:0];
		o.quat_w = q[3][15:0];
		o.stamp_us = stamp_now[39:0];
		o.last = (bone == BONES - 1);
		pose_expected = {pose_expected, o};
	endfunction

	function automatic void clear_pose_state();
		energy_acc = 0;
		sample_cnt = 0;
		last_rms = 0;
		sway_lvl = 0;
		nod_lvl = 0;
		raise_lvl = 0;
		osc_turns = 0;
		stamp_now = 0;
	endfunction

	// close a frame: RMS, onset, filters, oscillator, then 13 bones
	function automatic void close_frame();
		int unsigned r;
		int rms, onset, nod_tgt, sw, asw, sway_c, nod_c, raise_c;
		r = root_floor(energy_acc / eff_frame_len());
		rms = (r > 32767) ? 32767 : int'(r);
		onset = (rms > last_rms) ? rms - last_rms : 0;
		nod_tgt = (onset * 5) / 2;
		if (nod_tgt > 32767) nod_tgt = 32767;
		last_rms = rms;
		sway_lvl += mul_round(alpha_sway_reg, mul_round(rms, 13107) - sway_lvl);
		nod_lvl += mul_round(alpha_nod_reg, nod_tgt - nod_lvl);
		raise_lvl += mul_round(alpha_raise_reg, mul_round(rms, 19661) - raise_lvl);
		osc_turns = (osc_turns + step_base_reg + ((step_gain_reg * rms) >> 15)) & 32'hFFFF;
		sw = mul_round(sine_turns(osc_turns), raise_lvl);
		sway_c = clip(sway_lvl, 0, 2860);
		nod_c = clip(nod_lvl, 0, 4575);
		raise_c = clip(raise_lvl, 0, 8579);
		sw = clip(sw, -5719, 5719);
		asw = sw < 0 ? -sw : sw;
		push_bone(0, 0, 0, mul_round(sway_c, 13107));
		push_bone(1, 2, 0, mul_round(sw, 6554));
		push_bone(2, 2, 0, mul_round(-sw, 3277));
		push_bone(3, 0, 0, mul_round(nod_c, 13107));
		push_bone(4, 0, 0, mul_round(nod_c, 19661));
		push_bone(5, 2, 0, mul_round(raise_c, 9830));
		push_bone(6, 1, 0, mul_round(sw, 19661));
		push_bone(7, 2, 0, mul_round(asw, 9830));
		push_bone(8, -1, 0, 0);
		push_bone(9, 2, 1, mul_round(raise_c, 9830));
		push_bone(10, 1, 0, mul_round(-sw, 19661));
		push_bone(11, 2, 1, mul_round(asw, 9830));
		push_bone(12, -1, 0, 0);
		stamp_now = (stamp_now + period_reg) & 64'hFF_FFFF_FFFF;
		energy_acc = 0;
		sample_cnt = 0;
	endfunction

	function automatic void predict_word(in_word_t w);
		longint sq;
		case (w.command)
			CMD_SAMPLE: begin
				sq = longint'(w.sample) * longint'(w.sample);
				// saturate the energy sum at 2^42-1
				if (energy_acc > (64'd1 << 42) - 1 - sq) energy_acc = (64'd1 << 42) - 1;
				else energy_acc += sq;
				sample_cnt++;
				if (sample_cnt >= eff_frame_len()) close_frame();
			end
			CMD_CLOSE: if (sample_cnt > 0) close_frame();
			CMD_CLEAR: clear_pose_state();
			default: ;
		endcase
	endfunction

	// append a command word to the feed
	function automatic void feed(in_word_t w);
		word_feed = {word_feed, w};
	endfunction

	// ---------------------------------------------------------------
	// Driver: advance the feed queue, idle in random bursts
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) predict_word(in_data);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (word_feed.size() > 0) begin
					in_data <= word_feed[0];
					word_feed.delete(0);
					in_valid <= 1'b1;
					if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: stall out_ready in bursts, check each bone word, watchdog
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pose_expected.size() == 0) begin
					$error("unexpected bone word %p", out_data);
					error_count++;
				end else begin
					want = pose_expected[0];
					pose_expected.delete(0);
					if (out_data.bone_index !== want.bone_index) begin
						$error("bone_index: expected %0d, got %0d", want.bone_index, out_data.bone_index);
						error_count++;
					end
					if (out_data.quat_x !== want.quat_x) begin
						$error("quat_x: expected %0d, got %0d", want.quat_x, out_data.quat_x);
						error_count++;
					end
					if (out_data.quat_y !== want.quat_y) begin
						$error("quat_y: expected %0d, got %0d", want.quat_y, out_data.quat_y);
						error_count++;
					end
					if (out_data.quat_z !== want.quat_z) begin
						$error("quat_z: expected %0d, got %0d", want.quat_z, out_data.quat_z);
						error_count++;
					end
					if (out_data.quat_w !== want.quat_w) begin
						$error("quat_w: expected %0d, got %0d", want.quat_w, out_data.quat_w);
						error_count++;
					end
					if (out_data.stamp_us !== want.stamp_us) begin
						$error("stamp_us: expected %0d, got %0d", want.stamp_us, out_data.stamp_us);
						error_count++;
					end
					if (out_data.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, out_data.last);
						error_count++;
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 4) == 0) recv_stall = $urandom_range(1, 5);
			end
			// any accepted word on either side counts as progress
			if ((out_valid && out_ready) || (in_valid && in_ready)) hang_count = 0;
			else hang_count++;
			if (hang_count >= HANG_LIMIT) begin
				$display("audio_energy_gesture_pose_tb: done, errors");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	function automatic in_word_t make_word(logic [1:0] cmd, int s);
		in_word_t w;
		w.command = cmd;
		w.sample = s[15:0];
		return w;
	endfunction

	function automatic int rand_sample();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32767 : -32768;
			1: return int'($urandom_range(0, 200)) - 100;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// hold until the block has drained and the engine is surely quiet
	task automatic settle();
		while (word_feed.size() > 0 || in_valid || pose_expected.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[19:0];
		case (idx)
			REG_SPF:    frame_len_reg = val & 32'h1FFF;
			REG_ASWAY:  alpha_sway_reg = val & 32'h7FFF;
			REG_ANOD:   alpha_nod_reg = val & 32'h7FFF;
			REG_ARAISE: alpha_raise_reg = val & 32'h7FFF;
			REG_PBASE:  step_base_reg = val & 32'hFFFF;
			REG_PGAIN:  step_gain_reg = val & 32'hFFFF;
			REG_PERIOD: period_reg = val & 32'hFFFFF;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int unsigned pick(int unsigned lo, int unsigned hi);
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	initial begin
		frame_len_reg = 533;
		alpha_sway_reg = 2113;
		alpha_nod_reg = 11167;
		alpha_raise_reg = 4090;
		step_base_reg = 3277;
		step_gain_reg = 1092;
		period_reg = 33333;
		clear_pose_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, partial close, empty close, spare code, clear
		feed(make_word(CMD_SAMPLE, 32767));
		feed(make_word(CMD_SAMPLE, -32768));
		feed(make_word(CMD_SAMPLE, 0));
		feed(make_word(CMD_SAMPLE, 1));
		feed(make_word(CMD_SAMPLE, -1));
		feed(make_word(CMD_CLOSE, 0));
		feed(make_word(CMD_CLOSE, 0));
		feed(make_word(CMD_UNUSED, -1));
		feed(make_word(CMD_SAMPLE, 12345));
		feed(make_word(CMD_CLEAR, 0));
		feed(make_word(CMD_CLOSE, 0));
		settle();

		// frame length zero acts as one; period zero adds nothing
		write_reg(REG_SPF, 0);
		write_reg(REG_PERIOD, 0);
		feed(make_word(CMD_SAMPLE, -32768));
		feed(make_word(CMD_SAMPLE, 20000));
		settle();

		// frame length lowered mid-frame: frame ends at the next sample
		write_reg(REG_SPF, 10);
		write_reg(REG_PERIOD, 1);
		for (int i = 0; i < 6; i++) feed(make_word(CMD_SAMPLE, 32767));
		settle();
		write_reg(REG_SPF, 2);
		feed(make_word(CMD_SAMPLE, 32767));
		settle();

		// oversize frame length acts as the maximum: a short frame closed by padding
		write_reg(REG_SPF, 13'h1FFF);
		for (int i = 0; i < 4; i++) feed(make_word(CMD_SAMPLE, -32768));
		feed(make_word(CMD_CLOSE, 0));
		settle();

		// random phases over varied settings, extremes included
		for (int ph = 0; ph < 11; ph++) begin
			if (ph == 9) calm = 1'b1;
			write_reg(REG_SPF, (ph % 3 == 0) ? $urandom_range(1, 3) : $urandom_range(1, 12));
			write_reg(REG_ASWAY, pick(0, 32767));
			write_reg(REG_ANOD, pick(0, 32767));
			write_reg(REG_ARAISE, pick(0, 32767));
			write_reg(REG_PBASE, pick(0, 65535));
			write_reg(REG_PGAIN, pick(0, 65535));
			write_reg(REG_PERIOD, pick(0, 20'hFFFFF));
			for (int i = 0; i < 28; i++) begin
				case ($urandom_range(0, 29))
					0, 1: feed(make_word(CMD_CLOSE, rand_sample()));
					2: feed(make_word(CMD_CLEAR, rand_sample()));
					3: feed(make_word(CMD_UNUSED, rand_sample()));
					default: feed(make_word(CMD_SAMPLE, rand_sample()));
				endcase
			end
			settle();
		end

		if (error_count == 0) begin
			$display("audio_energy_gesture_pose_tb: done, clean");
		end else begin
			$display("audio_energy_gesture_pose_tb: done, errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
